// ----- design/modbus_read_holding_response_checker_macros.svh -----
// Assertion macros used by the checker RTL.
`ifndef MODBUS_READ_HOLDING_RESPONSE_CHECKER_MACROS_SVH
`define MODBUS_READ_HOLDING_RESPONSE_CHECKER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MBRHC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Same-cycle check failed.");

// The consequent must hold in the cycle after the antecedent.
`define MBRHC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Next-cycle check failed.");

`endif

// ----- design/mbrhc_pkg.sv -----
package mbrhc_pkg;

    localparam int MAX_FRAME_BYTES = 127;
    localparam int MIN_FRAME_BYTES = 4;
    localparam int STORE_DEPTH     = MAX_FRAME_BYTES + 1;
    localparam int ADDR_W          = $clog2(STORE_DEPTH);

    localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
    localparam logic [7:0]  ERROR_FLAG        = 8'h80;
    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'hA001;
    localparam logic [3:0]  MAX_DEST_SIZE     = 4'd8;
    localparam int          DATA_OFFSET       = 3;
    localparam int          FUNC_INDEX        = 1;
    localparam int          COUNT_INDEX       = 2;

    localparam logic [3:0] DEST_SIZE_RESET = 4'd4;
    localparam logic [1:0] DATA_TYPE_RESET = 2'd2;
    localparam logic [1:0] DT_IN_ORDER     = 2'd0;
    localparam logic [1:0] DT_PAIR_SWAP    = 2'd1;

    localparam logic REG_DEST_SIZE = 1'b0;
    localparam logic REG_DATA_TYPE = 1'b1;

    typedef enum logic [2:0] {
        STAT_OK          = 3'd0,
        STAT_TOO_SHORT   = 3'd1,
        STAT_CRC_ERROR   = 3'd2,
        STAT_COUNT_ERROR = 3'd3,
        STAT_EXCEPTION   = 3'd4,
        STAT_ERROR_NO_EX = 3'd5,
        STAT_BAD_FUNC    = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CHECK = 3'b010,
        ST_EMIT  = 3'b100
    } state_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- design/modbus_read_holding_response_checker.sv -----
// Channel  | Handshake                     | Payload
// ---------+-------------------------------+---------------------------------------
// input    | start, busy                   | rx_byte, frame_end
// result   | result_valid (strobe)         | data_byte, status, exception_code, last
// config   | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// A byte without an end mark is taken while idle and busy stays low.
// After an end mark the frame is checked in the next cycle; an error beat
// leaves then, while data beats follow one per cycle from the frame memory.
// Busy lasts through the check state, and after a good end through every data beat too.
// Reset clears the frame state and sets the destination size to 4 and data_type to 2.
// The receiver takes every beat in the cycle it appears.
`include "modbus_read_holding_response_checker_macros.svh"

module modbus_read_holding_response_checker
    import mbrhc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  rx_byte,
    input  logic        frame_end,
    output logic        result_valid,
    output logic [7:0]  data_byte,
    output logic [2:0]  status,
    output logic [7:0]  exception_code,
    output logic        last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   byte_total_reg, byte_total_next;
    logic [15:0]         crc_reg, crc_next;
    logic [15:0]         hist_reg, hist_next;
    logic [7:0]          prev_byte_reg, prev_byte_next;
    logic [ADDR_W-1:0]   match_len_reg, match_len_next;
    logic                zero_tail_reg, zero_tail_next;
    logic [7:0]          func_reg, func_next;
    logic [7:0]          bc_reg, bc_next;
    logic [2:0]          n_reg, n_next;
    logic [3:0]          dest_size_reg;
    logic [1:0]          data_type_reg;
    logic [7:0]          rd_data_reg;

    logic [7:0]          frame_store [STORE_DEPTH];

    logic                accept;
    logic                take_byte;
    logic                match_hit;
    logic                cfg_write;
    logic [3:0]          size;
    logic [2:0]          count;
    logic [7:0]          bc_req;
    logic [8:0]          len_need;
    status_t             check_status;
    logic                data_ok;
    logic                out_last;
    logic                clear_frame;
    logic [3:0]          rd_idx;
    logic [3:0]          src;
    logic [ADDR_W-1:0]   rd_addr;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign take_byte = accept && (byte_total_reg < ADDR_W'(MAX_FRAME_BYTES));
    assign match_hit = (byte_total_reg >= ADDR_W'(MIN_FRAME_BYTES - 1))
                       && (prev_byte_reg == hist_reg[7:0])
                       && (rx_byte == hist_reg[15:8]);

    // Configuration registers.
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_comb
    begin
        unique case (paddr[2])
            REG_DEST_SIZE: prdata = {28'd0, dest_size_reg};
            REG_DATA_TYPE: prdata = {30'd0, data_type_reg};
            default:       prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_size_reg <= DEST_SIZE_RESET;
            data_type_reg <= DATA_TYPE_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_DEST_SIZE)
            begin
                dest_size_reg <= pwdata[3:0];
            end
            else
            begin
                data_type_reg <= pwdata[1:0];
            end
        end
    end

    // Frame checks on the stored header and the trimmed length.
    always_comb
    begin
        size     = (dest_size_reg > MAX_DEST_SIZE) ? MAX_DEST_SIZE : dest_size_reg;
        count    = (size[3:1] == 3'd0) ? 3'd1 : size[3:1];
        bc_req   = {4'd0, count, 1'b0};
        len_need = 9'(DATA_OFFSET + 2) + {1'b0, bc_reg};
        if (byte_total_reg < ADDR_W'(MIN_FRAME_BYTES))
        begin
            check_status = STAT_TOO_SHORT;
        end
        else if ((match_len_reg == '0) || !zero_tail_reg)
        begin
            check_status = STAT_CRC_ERROR;
        end
        else if (func_reg == FUNC_READ_HOLDING)
        begin
            if ((bc_reg != bc_req) || ({2'd0, match_len_reg} < len_need))
            begin
                check_status = STAT_COUNT_ERROR;
            end
            else
            begin
                check_status = STAT_OK;
            end
        end
        else if (func_reg == (FUNC_READ_HOLDING | ERROR_FLAG))
        begin
            if (match_len_reg > ADDR_W'(MIN_FRAME_BYTES))
            begin
                check_status = STAT_EXCEPTION;
            end
            else
            begin
                check_status = STAT_ERROR_NO_EX;
            end
        end
        else
        begin
            check_status = STAT_BAD_FUNC;
        end
    end

    assign data_ok  = (check_status == STAT_OK);
    assign out_last = ({1'b0, n_reg} == (bc_reg[3:0] - 4'd1));

    // The read for the next beat is issued while the current beat leaves.
    assign rd_idx = (state_reg == ST_EMIT) ? ({1'b0, n_reg} + 4'd1) : 4'd0;

    always_comb
    begin
        case (data_type_reg)
            DT_IN_ORDER:  src = rd_idx;
            DT_PAIR_SWAP: src = rd_idx ^ 4'd1;
            default:      src = bc_reg[3:0] - 4'd1 - rd_idx;
        endcase
    end

    assign rd_addr = ADDR_W'(DATA_OFFSET) + {{(ADDR_W - 4){1'b0}}, src};

    always_ff @(posedge clk)
    begin
        if (take_byte)
        begin
            frame_store[byte_total_reg] <= rx_byte;
        end
        rd_data_reg <= frame_store[rd_addr];
    end

    assign clear_frame = ((state_reg == ST_CHECK) && !data_ok)
                         || ((state_reg == ST_EMIT) && out_last);

    always_comb
    begin
        state_next      = state_reg;
        byte_total_next = byte_total_reg;
        crc_next        = crc_reg;
        hist_next       = hist_reg;
        prev_byte_next  = prev_byte_reg;
        match_len_next  = match_len_reg;
        zero_tail_next  = zero_tail_reg;
        func_next       = func_reg;
        bc_next         = bc_reg;
        n_next          = n_reg;

        if (take_byte)
        begin
            byte_total_next = byte_total_reg + ADDR_W'(1);
            crc_next        = crc_byte(crc_reg, rx_byte);
            hist_next       = crc_reg;
            prev_byte_next  = rx_byte;
            if (byte_total_reg == ADDR_W'(FUNC_INDEX))
            begin
                func_next = rx_byte;
            end
            if (byte_total_reg == ADDR_W'(COUNT_INDEX))
            begin
                bc_next = rx_byte;
            end
            if (match_hit)
            begin
                match_len_next = byte_total_reg + ADDR_W'(1);
                zero_tail_next = 1'b1;
            end
            else if (rx_byte != 8'd0)
            begin
                zero_tail_next = 1'b0;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && frame_end)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                n_next     = 3'd0;
                state_next = data_ok ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                n_next = n_reg + 3'd1;
                if (out_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (clear_frame)
        begin
            byte_total_next = '0;
            crc_next        = CRC_INIT;
            hist_next       = CRC_INIT;
            match_len_next  = '0;
            zero_tail_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            byte_total_reg <= '0;
            crc_reg        <= CRC_INIT;
            hist_reg       <= CRC_INIT;
            match_len_reg  <= '0;
            zero_tail_reg  <= 1'b0;
            n_reg          <= 3'd0;
        end
        else
        begin
            state_reg      <= state_next;
            byte_total_reg <= byte_total_next;
            crc_reg        <= crc_next;
            hist_reg       <= hist_next;
            match_len_reg  <= match_len_next;
            zero_tail_reg  <= zero_tail_next;
            n_reg          <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_byte_reg <= prev_byte_next;
        func_reg      <= func_next;
        bc_reg        <= bc_next;
    end

    // Result beats.
    assign result_valid   = ((state_reg == ST_CHECK) && !data_ok) || (state_reg == ST_EMIT);
    assign status         = (state_reg == ST_EMIT) ? STAT_OK : check_status;
    assign data_byte      = (state_reg == ST_EMIT) ? rd_data_reg : 8'd0;
    assign exception_code = ((state_reg == ST_CHECK) && (check_status == STAT_EXCEPTION))
                            ? bc_reg : 8'd0;
    assign last           = (state_reg == ST_EMIT) ? out_last : 1'b1;

    `MBRHC_ASSERT_NOW(a_beat_only_busy, result_valid, busy)
    `MBRHC_ASSERT_NEXT(a_idle_after_last, result_valid && last, !busy)
    `MBRHC_ASSERT_NOW(a_error_is_last, result_valid && (status != STAT_OK), last)
    `MBRHC_ASSERT_NEXT(a_end_makes_busy, start && !busy && frame_end, busy)
    `MBRHC_ASSERT_NEXT(a_frame_cleared, result_valid && last, byte_total_reg == '0)

endmodule

// ----- sim/modbus_read_holding_response_checker_test.sv -----
module modbus_read_holding_response_checker_test;
    import mbrhc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 12;
    localparam logic [2:0] ADDR_DEST_SIZE = {REG_DEST_SIZE, 2'b00};
    localparam logic [2:0] ADDR_DATA_TYPE = {REG_DATA_TYPE, 2'b00};

    typedef struct packed {
        logic [7:0] data;
        status_t    st;
        logic [7:0] exc;
        logic       last;
    } reply_beat_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [7:0]  rx_byte;
    logic        frame_end;
    logic        result_valid;
    logic [7:0]  data_byte;
    logic [2:0]  status;
    logic [7:0]  exception_code;
    logic        last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Predicted state of the checker.
    logic [7:0]  frame_mem [0:STORE_DEPTH-1];
    int          rx_count;
    logic [15:0] crc_acc;
    logic [15:0] crc_hist [0:1];
    int          match_len;
    logic        zero_pad;
    logic [3:0]  cfg_dest_size;
    logic [1:0]  cfg_data_type;

    reply_beat_t expected_beats [$];
    reply_beat_t seen_beat;
    logic [7:0]  tx_frame [$];
    int          fail_count;
    int          cycle_count;
    int          sent_bytes;
    bit          steady;

    modbus_read_holding_response_checker u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .rx_byte        (rx_byte),
        .frame_end      (frame_end),
        .result_valid   (result_valid),
        .data_byte      (data_byte),
        .status         (status),
        .exception_code (exception_code),
        .last           (last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [15:0] crc16_update(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        r = acc ^ {8'h00, b};
        repeat (8)
        begin
            r = r[0] ? ({1'b0, r[15:1]} ^ CRC_POLY) : {1'b0, r[15:1]};
        end
        return r;
    endfunction

    function automatic int reply_count_bytes();
        int sz;
        int regs;
        sz = (cfg_dest_size > MAX_DEST_SIZE) ? int'(MAX_DEST_SIZE) : int'(cfg_dest_size);
        regs = sz / 2;
        if (regs == 0)
        begin
            regs = 1;
        end
        return 2 * regs;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
        begin
            return 0;
        end
        if (roll < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("Mismatch in %0s: got %0h, expected %0h", what, got, want);
        fail_count++;
    endtask

    task automatic push_beat(input logic [7:0] d, input status_t st, input logic [7:0] exc,
                             input logic lst);
        reply_beat_t beat;
        beat.data = d;
        beat.st = st;
        beat.exc = exc;
        beat.last = lst;
        expected_beats.push_back(beat);
    endtask

    task automatic clear_frame_state();
        rx_count = 0;
        crc_acc = CRC_INIT;
        crc_hist[0] = CRC_INIT;
        crc_hist[1] = CRC_INIT;
        match_len = 0;
        zero_pad = 1'b0;
    endtask

    // Mirrors the checker for one accepted byte and queues the beats it causes.
    task automatic predict_byte(input logic [7:0] b, input logic fe);
        int bc;
        int src;
        logic [7:0] func;
        if (rx_count < MAX_FRAME_BYTES)
        begin
            frame_mem[rx_count] = b;
            crc_hist[0] = crc_hist[1];
            crc_hist[1] = crc_acc;
            crc_acc = crc16_update(crc_acc, b);
            rx_count++;
            if (rx_count >= MIN_FRAME_BYTES && frame_mem[rx_count-2] == crc_hist[0][7:0]
                && b == crc_hist[0][15:8])
            begin
                match_len = rx_count;
                zero_pad = 1'b1;
            end
            else if (b != 8'h00)
            begin
                zero_pad = 1'b0;
            end
        end
        if (!fe)
        begin
            return;
        end
        func = frame_mem[FUNC_INDEX];
        if (rx_count < MIN_FRAME_BYTES)
        begin
            push_beat(8'h00, STAT_TOO_SHORT, 8'h00, 1'b1);
        end
        else if (match_len == 0 || !zero_pad)
        begin
            push_beat(8'h00, STAT_CRC_ERROR, 8'h00, 1'b1);
        end
        else if (func == FUNC_READ_HOLDING)
        begin
            bc = frame_mem[COUNT_INDEX];
            if (bc != reply_count_bytes() || match_len < DATA_OFFSET + 2 + bc)
            begin
                push_beat(8'h00, STAT_COUNT_ERROR, 8'h00, 1'b1);
            end
            else
            begin
                for (int n = 0; n < bc; n++)
                begin
                    if (cfg_data_type == DT_IN_ORDER)
                    begin
                        src = n;
                    end
                    else if (cfg_data_type == DT_PAIR_SWAP)
                    begin
                        src = n ^ 1;
                    end
                    else
                    begin
                        src = bc - 1 - n;
                    end
                    push_beat(frame_mem[DATA_OFFSET+src], STAT_OK, 8'h00, n + 1 == bc);
                end
            end
        end
        else if (func == (FUNC_READ_HOLDING | ERROR_FLAG))
        begin
            if (match_len > MIN_FRAME_BYTES)
            begin
                push_beat(8'h00, STAT_EXCEPTION, frame_mem[COUNT_INDEX], 1'b1);
            end
            else
            begin
                push_beat(8'h00, STAT_ERROR_NO_EX, 8'h00, 1'b1);
            end
        end
        else
        begin
            push_beat(8'h00, STAT_BAD_FUNC, 8'h00, 1'b1);
        end
        clear_frame_state();
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1)
        begin
            if (expected_beats.size() == 0)
            begin
                report_mismatch("unexpected beat, data_byte", data_byte, 0);
            end
            else
            begin
                seen_beat = expected_beats.pop_front();
                if (data_byte !== seen_beat.data)
                begin
                    report_mismatch("data_byte", data_byte, seen_beat.data);
                end
                if (status !== seen_beat.st)
                begin
                    report_mismatch("status", status, seen_beat.st);
                end
                if (exception_code !== seen_beat.exc)
                begin
                    report_mismatch("exception_code", exception_code, seen_beat.exc);
                end
                if (last !== seen_beat.last)
                begin
                    report_mismatch("last", last, seen_beat.last);
                end
            end
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic fe);
        @(negedge clk);
        start = 1'b1;
        rx_byte = b;
        frame_end = fe;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predict_byte(b, fe);
        sent_bytes++;
    endtask

    task automatic pause(input int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            rx_byte = 8'($urandom);
            frame_end = 1'($urandom);
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    task automatic wait_all_results();
        @(negedge clk);
        start = 1'b0;
        while (expected_beats.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        if (addr == ADDR_DEST_SIZE)
        begin
            cfg_dest_size = value[3:0];
        end
        else if (addr == ADDR_DATA_TYPE)
        begin
            cfg_data_type = value[1:0];
        end
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_config(input logic [3:0] vsize, input logic [1:0] dtype);
        wait_all_results();
        write_reg(ADDR_DEST_SIZE, {$urandom_range(0, 1) ? 28'($urandom) : 28'h0, vsize});
        write_reg(ADDR_DATA_TYPE, {$urandom_range(0, 1) ? 30'($urandom) : 30'h0, dtype});
    endtask

    task automatic begin_frame(input logic [7:0] func);
        tx_frame.delete();
        tx_frame.push_back(8'($urandom));
        tx_frame.push_back(func);
    endtask

    task automatic append_random(input int count);
        repeat (count) tx_frame.push_back(8'($urandom));
    endtask

    task automatic append_zeros(input int count);
        repeat (count) tx_frame.push_back(8'h00);
    endtask

    task automatic append_crc();
        logic [15:0] acc;
        acc = CRC_INIT;
        foreach (tx_frame[i])
        begin
            acc = crc16_update(acc, tx_frame[i]);
        end
        tx_frame.push_back(acc[7:0]);
        tx_frame.push_back(acc[15:8]);
    endtask

    task automatic build_read_reply(input int bc_field, input int data_len);
        begin_frame(FUNC_READ_HOLDING);
        tx_frame.push_back(bc_field[7:0]);
        append_random(data_len);
        append_crc();
    endtask

    task automatic build_exception(input bit with_code, input logic [7:0] code);
        begin_frame(FUNC_READ_HOLDING | ERROR_FLAG);
        if (with_code)
        begin
            tx_frame.push_back(code);
        end
        append_crc();
    endtask

    task automatic build_noise(input int count);
        tx_frame.delete();
        append_random(count);
    endtask

    task automatic send_frame();
        foreach (tx_frame[i])
        begin
            send_beat(tx_frame[i], i == tx_frame.size() - 1);
            if (!steady)
            begin
                pause(pick_gap());
            end
        end
    endtask

    task automatic test_reset_defaults();
        steady = 1'b1;
        build_read_reply(reply_count_bytes(), reply_count_bytes());
        send_frame();
    endtask

    task automatic test_orderings();
        steady = 1'b0;
        set_config(4'd0, DT_IN_ORDER);
        build_read_reply(reply_count_bytes(), reply_count_bytes());
        send_frame();
        set_config(4'd15, DT_PAIR_SWAP);
        build_read_reply(reply_count_bytes(), reply_count_bytes());
        send_frame();
        set_config(4'd8, 2'd3);
        build_read_reply(reply_count_bytes(), reply_count_bytes());
        send_frame();
        set_config(4'd6, DATA_TYPE_RESET);
        build_read_reply(reply_count_bytes(), reply_count_bytes());
        send_frame();
    endtask

    task automatic test_error_cases();
        build_noise(1);
        send_frame();
        build_noise(3);
        send_frame();
        build_read_reply(reply_count_bytes(), reply_count_bytes());
        tx_frame[tx_frame.size()-1] ^= 8'h01;
        send_frame();
        build_read_reply(reply_count_bytes(), reply_count_bytes());
        tx_frame.push_back(8'hA5);
        send_frame();
        build_read_reply(reply_count_bytes() + 2, reply_count_bytes() + 2);
        send_frame();
        build_read_reply(reply_count_bytes(), reply_count_bytes() - 1);
        send_frame();
        build_exception(1'b1, 8'hFF);
        send_frame();
        build_exception(1'b1, 8'h00);
        send_frame();
        build_exception(1'b0, 8'h00);
        send_frame();
        begin_frame(8'h04);
        append_random(3);
        append_crc();
        send_frame();
        begin_frame(8'h00);
        append_crc();
        send_frame();
    endtask

    task automatic test_zero_trim();
        build_read_reply(reply_count_bytes(), reply_count_bytes());
        append_zeros(3);
        send_frame();
        build_read_reply(reply_count_bytes(), reply_count_bytes());
        append_zeros(1);
        tx_frame.push_back(8'h80);
        append_zeros(1);
        send_frame();
    endtask

    task automatic test_overlong();
        build_read_reply(reply_count_bytes(), reply_count_bytes());
        append_zeros(MAX_FRAME_BYTES + 2 - tx_frame.size());
        send_frame();
    endtask

    task automatic send_random_frame();
        int kind;
        int want;
        int fn;
        kind = $urandom_range(0, 99);
        want = reply_count_bytes();
        if (kind < 50)
        begin
            build_read_reply(want, want);
            if ($urandom_range(0, 2) == 0)
            begin
                append_zeros($urandom_range(1, 3));
            end
        end
        else if (kind < 60)
        begin
            build_exception($urandom_range(0, 3) != 0, 8'($urandom));
        end
        else if (kind < 68)
        begin
            fn = $urandom_range(0, 12);
            if (fn == want)
            begin
                build_read_reply(want, $urandom_range(0, want - 1));
            end
            else
            begin
                build_read_reply(fn, fn);
            end
        end
        else if (kind < 75)
        begin
            fn = $urandom_range(0, 255);
            if (fn == FUNC_READ_HOLDING || fn == (FUNC_READ_HOLDING | ERROR_FLAG))
            begin
                fn = fn ^ 8'h40;
            end
            begin_frame(fn[7:0]);
            append_random($urandom_range(0, 6));
            append_crc();
        end
        else if (kind < 84)
        begin
            build_read_reply(want, want);
            fn = $urandom_range(0, tx_frame.size() - 1);
            tx_frame[fn] ^= 8'(1 << $urandom_range(0, 7));
        end
        else if (kind < 92)
        begin
            build_noise($urandom_range(1, 12));
        end
        else
        begin
            build_noise($urandom_range(1, 3));
        end
        send_frame();
    endtask

    task automatic test_random_traffic();
        int first_byte;
        int frames;
        for (int phase = 0; phase < 2; phase++)
        begin
            set_config(4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
            first_byte = sent_bytes;
            frames = 0;
            while (sent_bytes - first_byte < 12 || frames < 3)
            begin
                steady = ($urandom_range(0, 3) == 0);
                send_random_frame();
                frames++;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        rx_byte = 8'h00;
        frame_end = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        fail_count = 0;
        cycle_count = 0;
        sent_bytes = 0;
        steady = 1'b0;
        cfg_dest_size = DEST_SIZE_RESET;
        cfg_data_type = DATA_TYPE_RESET;
        clear_frame_state();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_orderings();
        test_error_cases();
        test_zero_trim();
        test_overlong();
        test_random_traffic();
        wait_all_results();

        if (fail_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/mbrhc_pkg.sv
design/modbus_read_holding_response_checker.sv
sim/modbus_read_holding_response_checker_test.sv
